>>> sv/stmax_pkg.sv
// stmax_pkg: payload structs, operation and result codes for the sparse
// table range-max engine. No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package stmax_pkg;

	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int VAL_W = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic signed [VAL_W-1:0] MOST_NEG = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]              operation;
		logic [IDX_W-1:0]        load_index;
		logic signed [VAL_W-1:0] load_value;
		logic [CNT_W-1:0]        element_count;
		logic [IDX_W-1:0]        left_index;
		logic [IDX_W-1:0]        right_index;
	} req_t;

	typedef struct packed {
		logic                    result_kind;
		logic signed [VAL_W-1:0] range_max;
		logic                    status;
	} rsp_t;

endpackage

`default_nettype wire

>>> sv/sparse_table_range_max.sv
// sparse_table_range_max: range-max engine over signed 32-bit values.
// Load and query transfers are taken one per cycle while idle and not held by a
// stalled answer; a query answer goes through the table read register, then the
// output register. A build fills one level after another through the single
// table write port, then reports; no transfers are taken meanwhile.
// arst_n clears control state and the element count; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_range_max #(
	parameter int DEPTH  = 1024,
	parameter int LEVELS = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  stmax_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output stmax_pkg::rsp_t   rsp
);

	localparam int CNT_W     = stmax_pkg::CNT_W;
	localparam int VAL_W     = stmax_pkg::VAL_W;
	localparam int POS_W     = $clog2(DEPTH);
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int ADDR_W    = LVL_W + POS_W;
	localparam int RAM_DEPTH = LEVELS * (2 ** POS_W);
	localparam int K_W       = $clog2(CNT_W);
	// largest count the 11-bit field can hold, capped by the table depth
	localparam int CNT_SAT   = (DEPTH < (2 ** CNT_W)) ? DEPTH : (2 ** CNT_W) - 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_BUILD = 3'b010,
		S_FIN   = 3'b100
	} state_t;

	// control
	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;      // element count of the last build
	logic [LVL_W-1:0]   lvl_q;      // level being filled
	logic [CNT_W-1:0]   pos_q;      // next position to read within the level

	// build pipeline (read issued, then max and write back)
	logic               bld_vld_s1;
	logic [ADDR_W-1:0]  bld_waddr_s1;
	logic               bld_inb_s1;

	// query pipeline
	logic               q_vld_s1;
	logic               q_bad_s1;

	// output register
	logic               rsp_vld_q;
	stmax_pkg::rsp_t    rsp_q;

	logic               accept;
	logic               is_load;
	logic               is_build;
	logic               is_query;
	logic               s1_adv;
	logic               fin_emit;

	// query decode
	logic [CNT_W-1:0]   left_w;
	logic [CNT_W-1:0]   right_w;
	logic [CNT_W-1:0]   span;
	logic [K_W-1:0]     q_k;
	logic [LVL_W-1:0]   q_lvl;
	logic [CNT_W-1:0]   q_pos_b;
	logic               q_bad;

	// build decode
	logic [CNT_W-1:0]   cnt_new;
	logic [31:0]        half;
	logic [31:0]        sum_b;
	logic               b_in;
	logic               bld_issue;
	logic               next_lvl_ok;

	// table ports
	logic               ld_we;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic               rd_en;
	logic [ADDR_W-1:0]  raddr_a;
	logic [ADDR_W-1:0]  raddr_b;
	logic [VAL_W-1:0]   rdata_a;
	logic [VAL_W-1:0]   rdata_b;
	logic signed [VAL_W-1:0] val_a;
	logic signed [VAL_W-1:0] val_b;
	logic signed [VAL_W-1:0] bld_b;
	logic signed [VAL_W-1:0] bld_max;
	logic signed [VAL_W-1:0] q_max;

	// ---------------------------------------------------------------
	// Handshake. The query stage drains into the output register
	// whenever that register is empty or its transfer completes.
	// ---------------------------------------------------------------
	assign s1_adv    = !rsp_vld_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && (!q_vld_s1 || s1_adv);
	assign accept    = req_valid && req_ready;
	assign is_load   = (req.operation == stmax_pkg::OP_LOAD);
	assign is_build  = (req.operation == stmax_pkg::OP_BUILD);
	assign is_query  = (req.operation == stmax_pkg::OP_QUERY);

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------
	// Query decode: range check against the current count, level by
	// priority encoding of the span, and the two window starts.
	// ---------------------------------------------------------------
	assign left_w  = CNT_W'(req.left_index);
	assign right_w = CNT_W'(req.right_index);
	assign q_bad   = (left_w > right_w) || (right_w >= cnt_q);
	assign span    = right_w - left_w + CNT_W'(1);

	always_comb begin
		q_k = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (span[b]) begin
				q_k = K_W'(b);
			end
		end
	end

	assign q_lvl   = (int'(q_k) > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(q_k);
	assign q_pos_b = right_w + CNT_W'(1) - (CNT_W'(1) << q_lvl);

	// ---------------------------------------------------------------
	// Build walk. Entry j of level L is max(L-1[j], L-1[j + half]),
	// where the second term is the most negative value past the count.
	// A level is finished only after its last write has landed, so the
	// next level never reads an entry still in flight.
	// ---------------------------------------------------------------
	assign cnt_new = (32'(req.element_count) > 32'(CNT_SAT)) ? CNT_W'(CNT_SAT)
		: req.element_count;
	assign half        = 32'd1 << (lvl_q - LVL_W'(1));
	assign sum_b       = 32'(pos_q) + half;
	assign b_in        = sum_b < 32'(cnt_q);
	assign bld_issue   = (state_q == S_BUILD) && (pos_q != cnt_q) && !q_vld_s1;
	assign next_lvl_ok = ((int'(lvl_q) + 1) < LEVELS)
		&& ((32'd1 << (int'(lvl_q) + 1)) <= 32'(cnt_q));
	assign fin_emit    = (state_q == S_FIN) && !q_vld_s1 && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			lvl_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && is_build) begin
						cnt_q <= cnt_new;
						lvl_q <= LVL_W'(1);
						pos_q <= '0;
						if (cnt_new >= CNT_W'(2)) begin
							state_q <= S_BUILD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_BUILD: begin
					if (bld_issue) begin
						pos_q <= pos_q + CNT_W'(1);
					end else if (pos_q == cnt_q && !bld_vld_s1) begin
						if (next_lvl_ok) begin
							lvl_q <= lvl_q + LVL_W'(1);
							pos_q <= '0;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (fin_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// build pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_vld_s1 <= 1'b0;
		end else begin
			bld_vld_s1 <= bld_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (bld_issue) begin
			bld_waddr_s1 <= {lvl_q, POS_W'(pos_q)};
			bld_inb_s1   <= b_in;
		end
	end

	// query pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_s1 <= 1'b0;
		end else if (accept && is_query) begin
			q_vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			q_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			q_bad_s1 <= q_bad;
		end
	end

	// ---------------------------------------------------------------
	// Table access. Loads write straight away; build writes come from
	// the stage after the read. The two never meet: loads are only
	// taken in idle, and build writes only happen during a build.
	// ---------------------------------------------------------------
	assign ld_we = accept && is_load && (32'(req.load_index) < 32'(DEPTH));

	assign val_a   = rdata_a;
	assign val_b   = rdata_b;
	assign bld_b   = bld_inb_s1 ? val_b : stmax_pkg::MOST_NEG;
	assign bld_max = (val_a > bld_b) ? val_a : bld_b;
	assign q_max   = (val_a > val_b) ? val_a : val_b;

	assign ram_we    = bld_vld_s1 || ld_we;
	assign ram_waddr = bld_vld_s1 ? bld_waddr_s1 : {LVL_W'(0), POS_W'(req.load_index)};
	assign ram_wdata = bld_vld_s1 ? bld_max : req.load_value;

	assign rd_en   = (accept && is_query) || bld_issue;
	assign raddr_a = bld_issue ? {lvl_q - LVL_W'(1), POS_W'(pos_q)}
		: {q_lvl, POS_W'(left_w)};
	assign raddr_b = bld_issue ? {lvl_q - LVL_W'(1), POS_W'(sum_b[CNT_W-1:0])}
		: {q_lvl, POS_W'(q_pos_b)};

	stmax_ram #(
		.WIDTH(VAL_W),
		.DEPTH(RAM_DEPTH)
	) u_table (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (rd_en),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// ---------------------------------------------------------------
	// Output register. A query answer has priority; the build report
	// waits until the query stage is empty, which keeps results in order.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if ((q_vld_s1 && s1_adv) || fin_emit) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_vld_s1 && s1_adv) begin
			rsp_q.result_kind <= stmax_pkg::KIND_QUERY;
			rsp_q.range_max   <= q_bad_s1 ? '0 : q_max;
			rsp_q.status      <= q_bad_s1 ? stmax_pkg::STATUS_BAD : stmax_pkg::STATUS_OK;
		end else if (fin_emit) begin
			rsp_q.result_kind <= stmax_pkg::KIND_BUILD;
			rsp_q.range_max   <= '0;
			rsp_q.status      <= stmax_pkg::STATUS_OK;
		end
	end

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req_ready)
		else $error("transfer taken outside idle");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		bld_vld_s1 |-> !ld_we)
		else $error("load and build write collide");

	a_read_owner: assert property (@(posedge clk) disable iff (!arst_n)
		q_vld_s1 |-> !bld_issue)
		else $error("build read clobbers pending query data");

	a_hold_read: assert property (@(posedge clk) disable iff (!arst_n)
		(q_vld_s1 && !s1_adv) |-> !rd_en)
		else $error("stalled query data overwritten");

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> !bld_vld_s1)
		else $error("build reported with write in flight");
`endif

endmodule

`default_nettype wire

>>> sv/stmax_ram.sv
// stmax_ram: generic RAM, one write port and two read ports with registered,
// enable-held read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stmax_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire
